// ===== src/assert_macros.svh =====
// assertion macros for the rtl files, included by the pid top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pidr_pkg.sv =====
// shared constants, types and helper functions for the per-channel pid block
package pidr_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // field widths
    localparam int CHAN_W    = 2;
    localparam int TARGET_W  = 9;
    localparam int MEAS_W    = 13;
    localparam int DRIVE_W   = 11;
    localparam int GAIN_W    = 16;
    localparam int LOW_W     = 11;
    localparam int HIGH_W    = 10;
    localparam int TOL_W     = 8;

    // internal widths
    localparam int ERR_W     = 14;
    localparam int INTEG_W   = 11;
    localparam int DERIV_W   = 15;
    localparam int SUM_W     = 15;
    localparam int TMAG_W    = TARGET_W + 1;
    localparam int BOUND_W   = TOL_W + TMAG_W;
    localparam int CHANGE_W  = ERR_W + TOL_W;
    localparam int FRAC_W    = 12;
    localparam int FRAC_MASK = (1 << FRAC_W) - 1;
    localparam int PP_W      = GAIN_W + 1 + ERR_W;
    localparam int PI_W      = GAIN_W + 1 + INTEG_W;
    localparam int PD_W      = GAIN_W + 1 + DERIV_W;
    localparam int ACC_W     = PD_W + 1;

    // stream packing
    localparam int S_TDATA_W = ((TARGET_W + MEAS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

    // apb port
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_LOW    = 3'd3,
        REG_OUT_HIGH   = 3'd4,
        REG_CHANGE_TOL = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0] prop_gain;
        logic        [GAIN_W-1:0] integ_gain;
        logic        [GAIN_W-1:0] deriv_gain;
        logic signed [LOW_W-1:0]  out_low;
        logic        [HIGH_W-1:0] out_high;
        logic        [TOL_W-1:0]  change_tol;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:  16'd614,
        integ_gain: 16'd1024,
        deriv_gain: 16'd492,
        out_low:    -11'sd160,
        out_high:   10'd160,
        change_tol: 8'd26
    };

    typedef struct packed {
        logic signed [ERR_W-1:0]   last_error;
        logic signed [INTEG_W-1:0] integral;
    } t_chan_state;

    // channel folded onto the state table, at most three compare-subtract steps
    function automatic logic [CH_IDX_W-1:0] chan_index(input logic [CHAN_W-1:0] ch);
        int v;
        v = int'(ch);
        for (int k = 0; k < (1 << CHAN_W) - 1; k++) begin
            if (v >= NUM_CHANNELS) begin
                v = v - NUM_CHANNELS;
            end
        end
        return v[CH_IDX_W-1:0];
    endfunction

    function automatic logic [ERR_W-1:0] err_mag(input logic signed [ERR_W-1:0] v);
        return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
    endfunction

endpackage

// ===== src/pidr_regs.sv =====
// apb configuration register bank for the pid block
module pidr_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidr_pkg::PADDR_W-1:0]   paddr,
    input  logic [pidr_pkg::PDATA_W-1:0]   pwdata,
    output logic [pidr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output pidr_pkg::t_cfg                 o_cfg
);
    import pidr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PROP_GAIN:  r_cfg.prop_gain  <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: r_cfg.integ_gain <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: r_cfg.deriv_gain <= pwdata[GAIN_W-1:0];
                REG_OUT_LOW:    r_cfg.out_low    <= signed'(pwdata[LOW_W-1:0]);
                REG_OUT_HIGH:   r_cfg.out_high   <= pwdata[HIGH_W-1:0];
                REG_CHANGE_TOL: r_cfg.change_tol <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PROP_GAIN:  prdata = PDATA_W'(r_cfg.prop_gain);
            REG_INTEG_GAIN: prdata = PDATA_W'(r_cfg.integ_gain);
            REG_DERIV_GAIN: prdata = PDATA_W'(r_cfg.deriv_gain);
            REG_OUT_LOW:    prdata = PDATA_W'(r_cfg.out_low);
            REG_OUT_HIGH:   prdata = PDATA_W'(r_cfg.out_high);
            REG_CHANGE_TOL: prdata = PDATA_W'(r_cfg.change_tol);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== src/pid_with_integral_reset.sv =====
// per-channel speed pid with integral clamp and integral reset, top level
//
// input stream: one word per control update, carrying the channel in tuser and
// the target and measured speeds in tdata. output stream: one word per input
// word, in the same order, carrying the channel in tuser and the clamped drive
// correction in tdata. gains, clamp limits and the change tolerance are set
// over the apb port and are meant to be changed only while no word is in flight.
//
// per-channel last error and integral live in a small state memory with a
// registered read: the read is issued when a word is accepted, the updated
// state is written back one stage later, and a same-channel write landing on
// the read edge is forwarded so updates back to back on one channel are exact.
//
// a result word passes the stage 1 to 4 registers and the output register.
// throughput: one word per cycle while the receiver keeps tready high, set by
// the read-modify-write of the state memory; each pipeline stage moves on its
// own, so the block keeps taking words while a finished result waits at
// the output. reset clears all channel states to zero at once and loads the
// default gains. a stalled receiver fills the five stages, then tready drops.
`include "assert_macros.svh"

module pid_with_integral_reset (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [pidr_pkg::S_TDATA_W-1:0]   i_s_tdata,  // target_speed, measured_speed, pad
    input  logic [pidr_pkg::CHAN_W-1:0]      i_s_tuser,  // channel
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [pidr_pkg::M_TDATA_W-1:0]   o_m_tdata,  // drive_correction, pad
    output logic [pidr_pkg::CHAN_W-1:0]      o_m_tuser,  // out_channel
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pidr_pkg::PADDR_W-1:0]     paddr,
    input  logic [pidr_pkg::PDATA_W-1:0]     pwdata,
    output logic [pidr_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import pidr_pkg::*;

    t_cfg cfg;

    pidr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- flow control ----------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic accept;

    assign ld_out     = !r_out_v || i_m_tready;
    assign ld4        = !r_s4_v || ld_out;
    assign ld3        = !r_s3_v || ld4;
    assign ld2        = !r_s2_v || ld3;
    assign ld1        = !r_s1_v || ld2;
    assign o_s_tready = ld1;
    assign accept     = i_s_tvalid && ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (ld1)    r_s1_v  <= i_s_tvalid;
            if (ld2)    r_s2_v  <= r_s1_v;
            if (ld3)    r_s3_v  <= r_s2_v;
            if (ld4)    r_s4_v  <= r_s3_v;
            if (ld_out) r_out_v <= r_s4_v;
        end
    end

    // ---------------- input decode ----------------
    logic signed [TARGET_W-1:0] in_target;
    logic signed [MEAS_W-1:0]   in_meas;
    logic signed [ERR_W-1:0]    in_err;
    logic signed [TMAG_W-1:0]   in_target_ext;
    logic [TMAG_W-1:0]          in_target_mag;
    logic [BOUND_W-1:0]         in_bound;
    logic [CH_IDX_W-1:0]        rd_idx;

    always_comb begin
        in_target     = signed'(i_s_tdata[TARGET_W-1:0]);
        in_meas       = signed'(i_s_tdata[TARGET_W+MEAS_W-1:TARGET_W]);
        in_err        = ERR_W'(in_target) - ERR_W'(in_meas);
        in_target_ext = TMAG_W'(in_target);
        in_target_mag = in_target_ext[TMAG_W-1] ? TMAG_W'(-in_target_ext)
                                                : TMAG_W'(in_target_ext);
        in_bound      = BOUND_W'(cfg.change_tol) * BOUND_W'(in_target_mag);
        rd_idx        = chan_index(i_s_tuser);
    end

    // ---------------- state memory ----------------
    t_chan_state         r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_mem_vld;
    t_chan_state         r_rd_data;
    logic                r_rd_vld;
    logic                r_fwd_hit;
    t_chan_state         r_fwd_data;
    logic                wr_en;
    logic [CH_IDX_W-1:0] wr_idx;
    t_chan_state         wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (accept) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (wr_en) begin
            r_mem_vld[wr_idx] <= 1'b1;
        end
    end

    // a write-back on the read edge to the same channel is forwarded
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_vld   <= r_mem_vld[rd_idx];
            r_fwd_hit  <= wr_en && (wr_idx == rd_idx);
            r_fwd_data <= wr_data;
        end
    end

    // ---------------- stage 1: integral and derivative ----------------
    logic [CHAN_W-1:0]        r_s1_ch;
    logic [CH_IDX_W-1:0]      r_s1_idx;
    logic signed [ERR_W-1:0]  r_s1_err;
    logic [BOUND_W-1:0]       r_s1_bound;
    logic                     r_s1_tzero;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch    <= i_s_tuser;
            r_s1_idx   <= rd_idx;
            r_s1_err   <= in_err;
            r_s1_bound <= in_bound;
            r_s1_tzero <= (in_target == '0);
        end
    end

    t_chan_state                prev_state;
    logic [ERR_W-1:0]           e_mag;
    logic [ERR_W-1:0]           p_mag;
    logic signed [ERR_W:0]      mag_diff;
    logic [ERR_W-1:0]           diff_mag;
    logic [CHANGE_W-1:0]        change;
    logic                       tol_ok;
    logic                       err_zero;
    logic signed [SUM_W-1:0]    integ_sum;
    logic signed [SUM_W-1:0]    lo_sum;
    logic signed [SUM_W-1:0]    hi_sum;
    logic signed [INTEG_W-1:0]  n_integ;
    logic signed [DERIV_W-1:0]  n_deriv;

    always_comb begin
        if (r_fwd_hit) begin
            prev_state = r_fwd_data;
        end else if (r_rd_vld) begin
            prev_state = r_rd_data;
        end else begin
            prev_state = '0;
        end

        e_mag    = err_mag(r_s1_err);
        p_mag    = err_mag(prev_state.last_error);
        mag_diff = signed'({1'b0, e_mag}) - signed'({1'b0, p_mag});
        diff_mag = mag_diff[ERR_W] ? ERR_W'(-mag_diff) : mag_diff[ERR_W-1:0];
        change   = {diff_mag, {TOL_W{1'b0}}};
        tol_ok   = change <= CHANGE_W'(r_s1_bound);
        err_zero = (r_s1_err == '0);

        integ_sum = SUM_W'(prev_state.integral) + SUM_W'(r_s1_err);
        lo_sum    = SUM_W'(cfg.out_low);
        hi_sum    = SUM_W'(signed'({1'b0, cfg.out_high}));

        // upper bound is tested first when the limits cross
        if (tol_ok && !err_zero) begin
            if (integ_sum > hi_sum) begin
                n_integ = INTEG_W'(hi_sum);
            end else if (integ_sum < lo_sum) begin
                n_integ = INTEG_W'(lo_sum);
            end else begin
                n_integ = INTEG_W'(integ_sum);
            end
        end else if (!tol_ok) begin
            n_integ = '0;
        end else begin
            n_integ = prev_state.integral;
        end

        n_deriv = DERIV_W'(r_s1_err) - DERIV_W'(prev_state.last_error);

        // standing still on a zero target
        if (r_s1_tzero && err_zero) begin
            n_integ = '0;
            n_deriv = '0;
        end
    end

    assign wr_en              = r_s1_v && ld2;
    assign wr_idx             = r_s1_idx;
    assign wr_data.last_error = r_s1_err;
    assign wr_data.integral   = n_integ;

    // ---------------- stage 2: gain products ----------------
    logic [CHAN_W-1:0]          r_s2_ch;
    logic [CH_IDX_W-1:0]        r_s2_idx;
    logic signed [ERR_W-1:0]    r_s2_err;
    logic signed [INTEG_W-1:0]  r_s2_integ;
    logic signed [DERIV_W-1:0]  r_s2_deriv;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_s2_ch    <= r_s1_ch;
            r_s2_idx   <= r_s1_idx;
            r_s2_err   <= r_s1_err;
            r_s2_integ <= n_integ;
            r_s2_deriv <= n_deriv;
        end
    end

    logic signed [PP_W-1:0] n_pp;
    logic signed [PI_W-1:0] n_pi;
    logic signed [PD_W-1:0] n_pd;

    always_comb begin
        n_pp = signed'({1'b0, cfg.prop_gain})  * r_s2_err;
        n_pi = signed'({1'b0, cfg.integ_gain}) * r_s2_integ;
        n_pd = signed'({1'b0, cfg.deriv_gain}) * r_s2_deriv;
    end

    // ---------------- stage 3: sum ----------------
    logic [CHAN_W-1:0]      r_s3_ch;
    logic signed [PP_W-1:0] r_s3_pp;
    logic signed [PI_W-1:0] r_s3_pi;
    logic signed [PD_W-1:0] r_s3_pd;

    always_ff @(posedge i_clk) begin
        if (r_s2_v && ld3) begin
            r_s3_ch <= r_s2_ch;
            r_s3_pp <= n_pp;
            r_s3_pi <= n_pi;
            r_s3_pd <= n_pd;
        end
    end

    logic signed [ACC_W-1:0] n_acc;

    assign n_acc = ACC_W'(r_s3_pp) + ACC_W'(r_s3_pi) + ACC_W'(r_s3_pd);

    // ---------------- stage 4: clamp and truncate ----------------
    logic [CHAN_W-1:0]       r_s4_ch;
    logic signed [ACC_W-1:0] r_s4_acc;

    always_ff @(posedge i_clk) begin
        if (r_s3_v && ld4) begin
            r_s4_ch  <= r_s3_ch;
            r_s4_acc <= n_acc;
        end
    end

    logic signed [ACC_W-1:0]   lo_sc;
    logic signed [ACC_W-1:0]   hi_sc;
    logic signed [ACC_W-1:0]   acc_trunc;
    logic signed [DRIVE_W-1:0] n_drive;

    always_comb begin
        lo_sc = ACC_W'(cfg.out_low) <<< FRAC_W;
        hi_sc = ACC_W'(signed'({1'b0, cfg.out_high})) <<< FRAC_W;
        // round toward zero on negative sums
        if (r_s4_acc[ACC_W-1]) begin
            acc_trunc = (r_s4_acc + ACC_W'(FRAC_MASK)) >>> FRAC_W;
        end else begin
            acc_trunc = r_s4_acc >>> FRAC_W;
        end
        // lower bound is tested first when the limits cross
        if (r_s4_acc < lo_sc) begin
            n_drive = cfg.out_low;
        end else if (r_s4_acc > hi_sc) begin
            n_drive = DRIVE_W'(signed'({1'b0, cfg.out_high}));
        end else begin
            n_drive = acc_trunc[DRIVE_W-1:0];
        end
    end

    // ---------------- output register ----------------
    logic [CHAN_W-1:0]         r_out_ch;
    logic signed [DRIVE_W-1:0] r_out_drive;

    always_ff @(posedge i_clk) begin
        if (r_s4_v && ld_out) begin
            r_out_ch    <= r_s4_ch;
            r_out_drive <= n_drive;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_ch;
    assign o_m_tdata  = M_TDATA_W'(unsigned'(r_out_drive));

    // ---------------- assertions ----------------
    `ASSERT_NOW(a_full_when_blocked, !o_s_tready, r_s1_v && r_s2_v && r_s3_v && r_s4_v && r_out_v, "input blocked with a free stage")
    `ASSERT_NEXT(a_fwd_same_chan, accept && wr_en && (wr_idx == rd_idx), r_fwd_hit && r_s2_v && (r_s2_idx == r_s1_idx), "state forward lost on same-channel update")

endmodule

// ===== tb/pid_with_integral_reset_tb.sv =====
// testbench for the per-channel speed pid: directed table, random updates, scoreboard
`timescale 1ns / 100ps

module pid_with_integral_reset_tb;
    import pidr_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int N_DIRECTED     = 22;
    localparam int N_PHASES       = 8;
    localparam int ITEMS_PER_PH   = 100;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        int ch;
        int tgt;
        int meas;
        bit typed;
        int want;
    } t_stim_row;

    typedef struct {
        int prop;
        int integ;
        int deriv;
        int low_bits;
        int high;
        int tol;
    } t_gain_set;

    typedef struct {
        logic [CHAN_W-1:0]         chan;
        logic signed [DRIVE_W-1:0] drive;
    } t_correction;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [CHAN_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [CHAN_W-1:0]     m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // shadow of the register file and the per-channel state
    int cfg_prop, cfg_integ, cfg_deriv, cfg_low, cfg_high, cfg_tol;
    int err_hist [NUM_CHANNELS];
    int integ_hist [NUM_CHANNELS];

    t_correction pending_corrections [$];
    int  mismatches = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    logic hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{0,    0,     0, 1,    0},
        '{1,  255, -4096, 1,  160},
        '{2, -256,  4095, 1, -160},
        '{3,  200,   190, 0,    0},
        '{3,  200,   190, 0,    0},
        '{3,  200,   200, 0,    0},
        '{0,  255,   100, 0,    0},
        '{0,  255,   100, 0,    0},
        '{0,  255,   100, 0,    0},
        '{0,  255,   100, 0,    0},
        '{0, -255,  -100, 0,    0},
        '{2, -255,  -100, 0,    0},
        '{2, -255,  -100, 0,    0},
        '{2, -255,  -100, 0,    0},
        '{3,    0,     0, 1,    0},
        '{1,    0,    37, 0,    0},
        '{1,    0,   -37, 0,    0},
        '{2,  255,  4095, 0,    0},
        '{3,   -1, -4096, 0,    0},
        '{0,    1,     0, 0,    0},
        '{1, -256, -4096, 0,    0},
        '{2,  255,   255, 0,    0}
    };

    pid_with_integral_reset dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // one control update: integral with tolerance gate, derivative, clamped output
    function automatic logic signed [DRIVE_W-1:0] predict_correction(input int ch,
                                                                     input int tgt,
                                                                     input int meas);
        int slot, err, prev, integ, deriv;
        longint change, bound, acc;
        logic signed [DRIVE_W-1:0] res;
        slot = ch % NUM_CHANNELS;
        err = tgt - meas;
        prev = err_hist[slot];
        integ = integ_hist[slot];
        change = longint'(iabs(iabs(err) - iabs(prev))) * 256;
        bound = longint'(cfg_tol) * longint'(iabs(tgt));
        if (change <= bound && err != 0) begin
            integ = integ + err;
            if (integ > cfg_high) begin
                integ = cfg_high;
            end else if (integ < cfg_low) begin
                integ = cfg_low;
            end
        end else if (change > bound) begin
            integ = 0;
        end
        deriv = err - prev;
        if (tgt == 0 && err == 0) begin
            integ = 0;
            deriv = 0;
        end
        acc = longint'(cfg_prop) * err + longint'(cfg_integ) * integ
            + longint'(cfg_deriv) * deriv;
        if (acc < longint'(cfg_low) * (1 << FRAC_W)) begin
            res = DRIVE_W'(cfg_low);
        end else if (acc > longint'(cfg_high) * (1 << FRAC_W)) begin
            res = DRIVE_W'(cfg_high);
        end else begin
            res = DRIVE_W'(acc / (1 << FRAC_W));
        end
        err_hist[slot] = err;
        integ_hist[slot] = integ;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // called at a rising edge; leaves psel high so back-to-back writes need one assignment
    task automatic write_reg(input t_reg_idx idx, input int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic write_config(input t_gain_set g);
        logic signed [LOW_W-1:0] low_s;
        write_reg(REG_PROP_GAIN, g.prop);
        write_reg(REG_INTEG_GAIN, g.integ);
        write_reg(REG_DERIV_GAIN, g.deriv);
        write_reg(REG_OUT_LOW, g.low_bits);
        write_reg(REG_OUT_HIGH, g.high);
        write_reg(REG_CHANGE_TOL, g.tol);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        low_s = LOW_W'(g.low_bits);
        cfg_prop = g.prop & 16'hFFFF;
        cfg_integ = g.integ & 16'hFFFF;
        cfg_deriv = g.deriv & 16'hFFFF;
        cfg_low = low_s;
        cfg_high = g.high & 10'h3FF;
        cfg_tol = g.tol & 8'hFF;
    endtask

    // offers one word and returns at the edge that accepts it, valid still high
    task automatic send_update(input int ch, input int tgt, input int meas,
                               input bit typed, input int want);
        logic [S_TDATA_W-1:0] w;
        t_correction c;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        w = '0;
        w[TARGET_W-1:0] = TARGET_W'(tgt);
        w[TARGET_W +: MEAS_W] = MEAS_W'(meas);
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= CHAN_W'(ch);
        do @(posedge i_clk); while (!s_tready);
        c.chan = CHAN_W'(ch);
        c.drive = predict_correction(ch, tgt, meas);
        if (typed) begin
            c.drive = DRIVE_W'(want);
        end
        pending_corrections.push_back(c);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_corrections.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly errors that drift within the tolerance band so the integral builds up
    task automatic make_random_update(output int ch, output int tgt, output int meas);
        int kind, lim, delta, err;
        ch = $urandom_range(3);
        kind = $urandom_range(99);
        tgt = int'($urandom_range(511)) - 256;
        meas = int'($urandom_range(8191)) - 4096;
        if (kind < 55) begin
            if (tgt == 0) begin
                tgt = 1;
            end
            lim = (cfg_tol * iabs(tgt)) / 256;
            delta = int'($urandom_range(2 * lim + 2)) - (lim + 1);
            err = ($urandom_range(9) == 0) ? -err_hist[ch % NUM_CHANNELS]
                                           : err_hist[ch % NUM_CHANNELS] + delta;
            meas = tgt - err;
            if (meas > 4095) begin
                meas = 4095;
            end else if (meas < -4096) begin
                meas = -4096;
            end
        end else if (kind < 65) begin
            tgt = 0;
            meas = 0;
        end else if (kind < 72) begin
            tgt = 0;
            meas = int'($urandom_range(64)) - 32;
        end else if (kind < 80) begin
            meas = tgt;
        end
    endtask

    // scoreboard on the result stream
    always @(posedge i_clk) begin
        t_correction c;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_corrections.size() == 0) begin
                report_mismatch("unexpected word, channel", int'(m_tuser), -1);
            end else begin
                c = pending_corrections.pop_front();
                if (m_tuser !== c.chan) begin
                    report_mismatch("out_channel", int'(m_tuser), int'(c.chan));
                end
                if ($signed(m_tdata[DRIVE_W-1:0]) !== c.drive) begin
                    report_mismatch("drive_correction", int'($signed(m_tdata[DRIVE_W-1:0])),
                                    int'(c.drive));
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int ch, tgt, meas, mode;
        t_gain_set g;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cfg_prop = CFG_RESET.prop_gain;
        cfg_integ = CFG_RESET.integ_gain;
        cfg_deriv = CFG_RESET.deriv_gain;
        cfg_low = CFG_RESET.out_low;
        cfg_high = CFG_RESET.out_high;
        cfg_tol = CFG_RESET.change_tol;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            err_hist[i] = 0;
            integ_hist[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_update(directed_rows[i].ch, directed_rows[i].tgt, directed_rows[i].meas,
                        directed_rows[i].typed, directed_rows[i].want);
        end
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: g = '{65535, 65535, 65535, 11'h401, 1023, 255};
                1: g = '{0, 0, 0, 0, 0, 0};
                // lower limit above the upper one
                2: g = '{4096, 2048, 1024, 300, 100, 40};
                3: g = '{614, 1024, 492, 11'h400, 1023, 26};
                default: begin
                    g.prop = $urandom_range(65535);
                    g.integ = $urandom_range(65535);
                    g.deriv = $urandom_range(65535);
                    g.low_bits = $urandom_range(1) ? (-int'($urandom_range(1023))) & 11'h7FF
                                                   : int'($urandom_range(2047));
                    g.high = $urandom_range(1023);
                    g.tol = $urandom_range(255);
                end
            endcase
            write_config(g);
            mode = ph % 4;
            idle_pct = (mode == 1) ? 71 : (mode == 3) ? 8 : 0;
            stall_pct <= (mode == 2) ? 71 : (mode == 3) ? 8 : 0;
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                if (ph == 4 && n == 10) begin
                    hold_req <= 1'b1;
                end
                // pause the sender until the pipeline is empty
                if (ph == 5 && n == 50) begin
                    drain_results();
                end
                make_random_update(ch, tgt, meas);
                send_update(ch, tgt, meas, 1'b0, 0);
            end
            drain_results();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pidr_pkg.sv
src/pidr_regs.sv
src/pid_with_integral_reset.sv
tb/pid_with_integral_reset_tb.sv
